FILE: rtl/pcfwrl_pkg.sv
// ----------------------------------------------------------------------------
// pcfwrl_pkg: shared types and constants of the per-client rate limiter
// Table size, field widths, register indexes, verdict codes and the request
// token that travels down the row of client cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pcfwrl_pkg;

    // Number of client cells in the row
    localparam int CLIENT_ENTRIES = 64;

    localparam int KEY_W    = 32;
    localparam int TIME_W   = 32;
    localparam int COUNT_W  = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_REQUESTS  = 2'd0,
        REG_WINDOW_LENGTH = 2'd1
    } cfg_reg_t;

    // Result codes
    typedef enum logic [1:0] {
        VERDICT_ALLOWED   = 2'd0,
        VERDICT_LIMITED   = 2'd1,
        VERDICT_UNTRACKED = 2'd2
    } verdict_t;

    // Request token handed from cell to cell. Once a cell owns the key it
    // marks the token resolved and loads the updated count and window start.
    typedef struct packed {
        logic               valid;
        logic               resolved;
        logic [KEY_W-1:0]   key;
        logic [TIME_W-1:0]  now;
        logic [COUNT_W-1:0] count;
        logic [TIME_W-1:0]  wstart;
    } token_t;

endpackage

`default_nettype wire

FILE: rtl/pcfwrl_cell.sv
// ----------------------------------------------------------------------------
// pcfwrl_cell: one client entry of the rate limiter row
// Holds key, count and window start of one client. Matches or claims the
// passing request, updates its entry, and forwards the token one cell on.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pcfwrl_cell (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire pcfwrl_pkg::token_t              tok_in,
    input  wire logic [pcfwrl_pkg::TIME_W-1:0]   window_length,
    output pcfwrl_pkg::token_t                   tok_out
);

    logic                             valid_reg;
    logic                             valid_next;
    logic [pcfwrl_pkg::KEY_W-1:0]     key_reg;
    logic [pcfwrl_pkg::KEY_W-1:0]     key_next;
    logic [pcfwrl_pkg::COUNT_W-1:0]   count_reg;
    logic [pcfwrl_pkg::COUNT_W-1:0]   count_next;
    logic [pcfwrl_pkg::TIME_W-1:0]    wstart_reg;
    logic [pcfwrl_pkg::TIME_W-1:0]    wstart_next;
    pcfwrl_pkg::token_t               tok_reg;
    pcfwrl_pkg::token_t               tok_next;

    logic                             take;
    logic                             restart;
    logic [pcfwrl_pkg::COUNT_W-1:0]   base_count;
    logic [pcfwrl_pkg::TIME_W-1:0]    base_wstart;
    logic [pcfwrl_pkg::TIME_W-1:0]    elapsed;
    logic [pcfwrl_pkg::COUNT_W-1:0]   win_count;
    logic [pcfwrl_pkg::TIME_W-1:0]    win_wstart;
    logic [pcfwrl_pkg::COUNT_W-1:0]   upd_count;

    // Entries fill from the low end and are never freed, so the first free
    // cell an unresolved token reaches means the key is not in the table.
    assign take = tok_in.valid && !tok_in.resolved &&
                  (!valid_reg || (key_reg == tok_in.key));

    // A freshly claimed entry starts at count zero with the window at now
    assign base_count  = valid_reg ? count_reg  : '0;
    assign base_wstart = valid_reg ? wstart_reg : tok_in.now;

    // Window expiry; time going backwards keeps the window
    assign elapsed = tok_in.now - base_wstart;
    assign restart = (tok_in.now > base_wstart) && (elapsed > window_length);

    assign win_count  = restart ? '0 : base_count;
    assign win_wstart = restart ? tok_in.now : base_wstart;

    // Saturating increment
    assign upd_count = (win_count == pcfwrl_pkg::COUNT_MAX) ? win_count
                                                            : win_count + 1'b1;

    // Entry update and token forwarding
    always_comb
    begin
        valid_next  = valid_reg;
        key_next    = key_reg;
        count_next  = count_reg;
        wstart_next = wstart_reg;
        tok_next    = tok_in;
        if (take)
        begin
            valid_next        = 1'b1;
            key_next          = tok_in.key;
            count_next        = upd_count;
            wstart_next       = win_wstart;
            tok_next.resolved = 1'b1;
            tok_next.count    = upd_count;
            tok_next.wstart   = win_wstart;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    // Entry payload, meaningful only once valid
    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        count_reg  <= count_next;
        wstart_reg <= wstart_next;
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire

FILE: rtl/pcfwrl_verdict.sv
// ----------------------------------------------------------------------------
// pcfwrl_verdict: verdict and retry time at the end of the cell row
// Turns the token leaving the last cell into a result transaction and holds
// it in the output register until the receiver takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pcfwrl_verdict (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire pcfwrl_pkg::token_t              tok_in,
    input  wire logic [pcfwrl_pkg::COUNT_W-1:0]  max_requests,
    input  wire logic [pcfwrl_pkg::TIME_W-1:0]   window_length,
    input  wire logic                            out_stall,
    output logic                                 out_valid,
    output logic [1:0]                           verdict,
    output logic [pcfwrl_pkg::TIME_W-1:0]        retry_after
);

    logic                             out_valid_reg;
    logic                             out_valid_next;
    pcfwrl_pkg::verdict_t             verdict_reg;
    pcfwrl_pkg::verdict_t             verdict_next;
    logic [pcfwrl_pkg::TIME_W-1:0]    retry_reg;
    logic [pcfwrl_pkg::TIME_W-1:0]    retry_next;

    logic                             limited;
    logic [pcfwrl_pkg::TIME_W:0]      reset_at;
    logic [pcfwrl_pkg::TIME_W:0]      remain;
    logic [pcfwrl_pkg::TIME_W-1:0]    remain_sat;

    assign limited = tok_in.count > max_requests;

    // Seconds to the end of the window, no wrap, saturated to 32 bits
    assign reset_at = {1'b0, tok_in.wstart} + {1'b0, window_length};
    assign remain   = (reset_at > {1'b0, tok_in.now}) ? reset_at - {1'b0, tok_in.now}
                                                       : '0;
    assign remain_sat = remain[pcfwrl_pkg::TIME_W] ? {pcfwrl_pkg::TIME_W{1'b1}}
                                                   : remain[pcfwrl_pkg::TIME_W-1:0];

    // Output register load and drain
    always_comb
    begin
        out_valid_next = out_valid_reg;
        verdict_next   = verdict_reg;
        retry_next     = retry_reg;
        if (tok_in.valid)
        begin
            out_valid_next = 1'b1;
            if (!tok_in.resolved)
            begin
                verdict_next = pcfwrl_pkg::VERDICT_UNTRACKED;
                retry_next   = '0;
            end
            else if (limited)
            begin
                verdict_next = pcfwrl_pkg::VERDICT_LIMITED;
                retry_next   = remain_sat;
            end
            else
            begin
                verdict_next = pcfwrl_pkg::VERDICT_ALLOWED;
                retry_next   = '0;
            end
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        verdict_reg <= verdict_next;
        retry_reg   <= retry_next;
    end

    assign out_valid   = out_valid_reg;
    assign verdict     = verdict_reg;
    assign retry_after = retry_reg;

endmodule

`default_nettype wire

FILE: rtl/per_client_fixed_window_rate_limiter.sv
// ----------------------------------------------------------------------------
// per_client_fixed_window_rate_limiter: per-client fixed-window request limiter
// Counts requests per client key in fixed time windows and returns a verdict
// of allowed, limited (with seconds to retry) or untracked (table full).
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries client_key and now_time; the
//   output channel (out_valid / out_stall) returns verdict and retry_after,
//   one result transaction per request, in order.
//   Configuration: cfg_write with cfg_index 0 sets max_requests (cfg_data
//   low 16 bits), index 1 sets window_length; other indexes are ignored.
//   Write only while no request is in flight.
//   Each request walks a row of CLIENT_ENTRIES client cells, one cell per
//   cycle. One request is in flight at a time: in_stall stays high from
//   acceptance until the result is taken, so a new request is accepted
//   only after the result of the previous one has been taken.
//   A stalled result is held in the output register with all fields stable.
//   Reset empties the table (no clearing pass needed) and loads
//   max_requests = 100 and window_length = 60.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module per_client_fixed_window_rate_limiter (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // configuration
    input  wire logic                              cfg_write,
    input  wire logic [pcfwrl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [pcfwrl_pkg::CFG_DATA_W-1:0] cfg_data,
    // requests
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [pcfwrl_pkg::KEY_W-1:0]      client_key,
    input  wire logic [pcfwrl_pkg::TIME_W-1:0]     now_time,
    // results
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [1:0]                             verdict,
    output logic [pcfwrl_pkg::TIME_W-1:0]          retry_after
);

    logic [pcfwrl_pkg::COUNT_W-1:0]  max_requests_reg;
    logic [pcfwrl_pkg::COUNT_W-1:0]  max_requests_next;
    logic [pcfwrl_pkg::TIME_W-1:0]   window_length_reg;
    logic [pcfwrl_pkg::TIME_W-1:0]   window_length_next;
    logic                            busy_reg;
    logic                            busy_next;

    logic                            in_accept;
    logic                            out_accept;
    pcfwrl_pkg::token_t              chain_tok [0:pcfwrl_pkg::CLIENT_ENTRIES];
    logic [pcfwrl_pkg::CLIENT_ENTRIES-1:0] cell_busy;

    // Configuration registers
    always_comb
    begin
        max_requests_next  = max_requests_reg;
        window_length_next = window_length_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                pcfwrl_pkg::REG_MAX_REQUESTS:
                    max_requests_next = cfg_data[pcfwrl_pkg::COUNT_W-1:0];
                pcfwrl_pkg::REG_WINDOW_LENGTH:
                    window_length_next = cfg_data[pcfwrl_pkg::TIME_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // One request in flight, from acceptance until its result is taken
    assign in_accept  = in_valid && !busy_reg;
    assign out_accept = out_valid && !out_stall;
    assign in_stall   = busy_reg;

    always_comb
    begin
        busy_next = busy_reg;
        if (in_accept)
        begin
            busy_next = 1'b1;
        end
        else if (out_accept)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_requests_reg  <= 16'd100;
            window_length_reg <= 32'd60;
            busy_reg          <= 1'b0;
        end
        else
        begin
            max_requests_reg  <= max_requests_next;
            window_length_reg <= window_length_next;
            busy_reg          <= busy_next;
        end
    end

    // Token entering the first cell
    always_comb
    begin
        chain_tok[0]          = '0;
        chain_tok[0].valid    = in_accept;
        chain_tok[0].resolved = 1'b0;
        chain_tok[0].key      = client_key;
        chain_tok[0].now      = now_time;
    end

    // Row of client cells
    genvar gi;
    generate
        for (gi = 0; gi < pcfwrl_pkg::CLIENT_ENTRIES; gi++)
        begin : g_cell
            pcfwrl_cell u_cell (
                .clk           (clk),
                .rst_n         (rst_n),
                .tok_in        (chain_tok[gi]),
                .window_length (window_length_reg),
                .tok_out       (chain_tok[gi+1])
            );
            assign cell_busy[gi] = chain_tok[gi+1].valid;
        end
    endgenerate

    // Verdict and output register
    pcfwrl_verdict u_verdict (
        .clk           (clk),
        .rst_n         (rst_n),
        .tok_in        (chain_tok[pcfwrl_pkg::CLIENT_ENTRIES]),
        .max_requests  (max_requests_reg),
        .window_length (window_length_reg),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .verdict       (verdict),
        .retry_after   (retry_after)
    );

    // Never more than one request token in the row
    a_single_token: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(cell_busy) <= 1)
        else $error("more than one request token in the cell row");

    // A token leaving the row never meets a held result
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        chain_tok[pcfwrl_pkg::CLIENT_ENTRIES].valid |-> !out_valid)
        else $error("result register overwritten while still valid");

    // A pending result or a token in the row implies the block is busy
    a_busy_cover: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid || (cell_busy != '0)) |-> busy_reg)
        else $error("work in flight while block reports idle");

    // An accepted request blocks the input and enters the cell row on the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (busy_reg && chain_tok[1].valid))
        else $error("accepted request did not enter the cell row");

endmodule

`default_nettype wire
